[sv/fwlt_pkg.sv]
// ----------------------------------------------------------------------------
// fwlt_pkg
// Shared codes and types for the wear-levelling flash translator.
// ----------------------------------------------------------------------------
`default_nettype none

package fwlt_pkg;

	localparam int LOGICAL_BLOCKS = 32;
	localparam int LB_W           = 5;
	localparam int BLK_OUT_W      = 5;
	localparam int THR_W          = 16;

	localparam logic [THR_W-1:0] THR_RESET = 16'd5;

	// request kinds
	localparam logic [1:0] MODE_READ  = 2'd0;
	localparam logic [1:0] MODE_WRITE = 2'd1;
	localparam logic [1:0] MODE_ERASE = 2'd2;

	// disk commands
	localparam logic [2:0] CMD_NONE  = 3'd0;
	localparam logic [2:0] CMD_READ  = 3'd1;
	localparam logic [2:0] CMD_WRITE = 3'd2;
	localparam logic [2:0] CMD_ZERO  = 3'd3;
	localparam logic [2:0] CMD_COPY  = 3'd4;

	// status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_UNMAPPED = 2'd1;
	localparam logic [1:0] ST_NOFREE   = 2'd2;

	// control from the sequencer to the shared compare unit
	typedef struct packed {
		logic sample;  // a block entry is on the read data this cycle
		logic first;   // that entry is block 0, restart the search
		logic want;    // free flag value being searched for
		logic thr_chk; // compare best count against the threshold
	} scan_ctrl_t;

endpackage

`default_nettype wire

[sv/fwlt_min_scan.sv]
// ----------------------------------------------------------------------------
// fwlt_min_scan
// Shared compare unit: least-worn search over streamed block entries, and
// the wear threshold compare on the winner.
// ----------------------------------------------------------------------------
`default_nettype none

module fwlt_min_scan #(
	parameter int PW = 5,
	parameter int CW = 16
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire fwlt_pkg::scan_ctrl_t     ctrl,
	input  wire logic [PW-1:0]            smp_idx,
	input  wire logic [CW-1:0]            smp_cnt,
	input  wire logic                     smp_free,
	input  wire logic [fwlt_pkg::THR_W-1:0] thr,
	output logic                          found,
	output logic [PW-1:0]                 best_idx,
	output logic [CW-1:0]                 best_cnt,
	output logic                          lt
);
	import fwlt_pkg::*;

	localparam int MW = (CW > THR_W) ? CW : THR_W;

	logic          found_q;
	logic [PW-1:0] best_idx_q;
	logic [CW-1:0] best_cnt_q;
	logic [MW-1:0] cmp_a;
	logic [MW-1:0] cmp_b;
	logic          match;
	logic          take;

	// one comparator, operands switched by what the sequencer is doing
	always_comb begin
		if (ctrl.thr_chk) begin
			cmp_a = MW'(best_cnt_q);
			cmp_b = MW'(thr);
		end else begin
			cmp_a = MW'(smp_cnt);
			cmp_b = MW'(best_cnt_q);
		end
	end

	assign lt    = cmp_a < cmp_b;
	assign match = smp_free == ctrl.want;
	// strict less-than keeps the lowest index on a tie
	assign take  = ctrl.sample && match && (ctrl.first || !found_q || lt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctrl.sample) begin
			found_q <= ctrl.first ? match : (found_q | match);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_idx_q <= smp_idx;
			best_cnt_q <= smp_cnt;
		end
	end

	assign found    = found_q;
	assign best_idx = best_idx_q;
	assign best_cnt = best_cnt_q;

endmodule

`default_nettype wire

[sv/flash_wear_leveling_translator_unit.sv]
// ----------------------------------------------------------------------------
// flash_wear_leveling_translator_unit
// Logical-to-physical block translator with wear levelling.
// ----------------------------------------------------------------------------
// Requests arrive on the s_axis channel (tuser = mode, tdata = logical block).
// Each request produces a run of one to four disk commands on m_axis, the
// final one flagged with tlast. Mode 3 produces nothing.
// One request at a time: s_axis_tready is high only while the sequencer is
// idle. A write takes one sweep over all NUM_BLOCKS status entries to find
// the least-worn free block, a second sweep for the least-worn used block
// when migration is due, and a sweep of up to 32 map entries to retarget
// the migrated block. The sweeps run one after another over the single
// status memory read port and the one shared comparator.
// After reset the status memory is cleared one entry a cycle (every block
// free with a zero count) before the first request is taken; the threshold
// register may be written meanwhile.
// Commands go through a one-deep output register; when m_axis stalls the
// sequencer holds until that register is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module flash_wear_leveling_translator_unit #(
	parameter int NUM_BLOCKS  = 32,
	parameter int COUNT_WIDTH = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// configuration: wear threshold
	input  wire logic                          cfg_we,
	input  wire logic [fwlt_pkg::THR_W-1:0]    cfg_wdata,
	// requests
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	input  wire logic [7:0]                    s_axis_tdata,  // [4:0] logical_block
	input  wire logic [1:0]                    s_axis_tuser,  // [1:0] mode
	// disk commands
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	output logic [15:0]                        m_axis_tdata,  // [4:0] source_block,
	                                                          // [9:5] target_block,
	                                                          // [11:10] status
	output logic [2:0]                         m_axis_tuser,  // [2:0] command
	output logic                               m_axis_tlast
);
	import fwlt_pkg::*;

	localparam int PW  = $clog2(NUM_BLOCKS);
	localparam int CW  = COUNT_WIDTH;
	localparam int SPW = $clog2(NUM_BLOCKS + 1);
	localparam logic [SPW-1:0] SP_END  = SPW'(NUM_BLOCKS);
	localparam logic [SPW-1:0] SP_LAST = SPW'(NUM_BLOCKS - 1);
	localparam logic [LB_W:0]  RP_END  = (LB_W + 1)'(LOGICAL_BLOCKS);

	typedef enum logic [12:0] {
		S_CLEAR     = 13'b0000000000001,
		S_IDLE      = 13'b0000000000010,
		S_LOOKUP    = 13'b0000000000100,
		S_REPLY     = 13'b0000000001000,
		S_OLD_EMIT  = 13'b0000000010000,
		S_OLD_WR    = 13'b0000000100000,
		S_FREE_SCAN = 13'b0000001000000,
		S_THR       = 13'b0000010000000,
		S_USED_SCAN = 13'b0000100000000,
		S_COPY      = 13'b0001000000000,
		S_REMAP     = 13'b0010000000000,
		S_USED_ZERO = 13'b0100000000000,
		S_GIVE      = 13'b1000000000000
	} state_t;

	function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] c);
		return (&c) ? c : c + 1'b1;
	endfunction

	function automatic logic [BLK_OUT_W-1:0] blk_out(input logic [PW-1:0] b);
		return BLK_OUT_W'(b);
	endfunction

	state_t state_q, state_d;

	logic [THR_W-1:0]          thr_q;
	logic [LOGICAL_BLOCKS-1:0] valid_q;
	logic [1:0]                mode_q;
	logic [LB_W-1:0]           lb_q;
	logic [PW-1:0]             old_q, aim_q, used_q, give_q;
	logic [CW-1:0]             aim_cnt_q, used_cnt_q, give_cnt_q;

	// block status memory: {free, erase count}
	logic [CW:0]   bm [NUM_BLOCKS];
	logic [PW-1:0] bm_raddr, bm_waddr;
	logic [CW:0]   bm_rdata, bm_wdata;
	logic          bm_we;

	// logical map memory, valid bits kept in valid_q
	logic [PW-1:0] mm [LOGICAL_BLOCKS];
	logic [LB_W-1:0] mm_raddr, mm_waddr;
	logic [PW-1:0] mm_rdata, mm_wdata;
	logic          mm_we;

	// sweep counters and sample alignment
	logic [SPW-1:0]  sp_q;
	logic            smp_vld_s1;
	logic [PW-1:0]   smp_idx_s1;
	logic [LB_W:0]   rp_q;
	logic            rm_vld_s1;
	logic [LB_W-1:0] rm_idx_s1;

	scan_ctrl_t    scan_ctl;
	logic          found, lt;
	logic [PW-1:0] best_idx;
	logic [CW-1:0] best_cnt;

	logic in_scan, scan_done, map_hit, remap_hit, remap_end, in_acc;
	logic emit_req, emit_go, out_free;

	logic [2:0]           e_cmd;
	logic [BLK_OUT_W-1:0] e_src, e_dst;
	logic [1:0]           e_st;
	logic                 e_last;

	logic                 m_vld_q;
	logic [2:0]           m_cmd_q;
	logic [BLK_OUT_W-1:0] m_src_q, m_dst_q;
	logic [1:0]           m_st_q;
	logic                 m_last_q;

	assign s_axis_tready = state_q == S_IDLE;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign map_hit       = valid_q[lb_q];
	assign in_scan       = (state_q == S_FREE_SCAN) || (state_q == S_USED_SCAN);
	assign scan_done     = in_scan && (sp_q == SP_END) && !smp_vld_s1;
	assign remap_hit     = (state_q == S_REMAP) && rm_vld_s1 && valid_q[rm_idx_s1]
	                       && (mm_rdata == used_q);
	assign remap_end     = (rp_q == RP_END) && !rm_vld_s1;
	assign out_free      = !m_vld_q || m_axis_tready;
	assign emit_go       = emit_req && out_free;

	// ---------------- sequencer ----------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (sp_q == SP_LAST) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_acc) state_d = S_LOOKUP;
			end
			S_LOOKUP: begin
				case (mode_q)
					MODE_READ:  state_d = S_REPLY;
					MODE_ERASE: state_d = map_hit ? S_OLD_EMIT : S_REPLY;
					MODE_WRITE: state_d = map_hit ? S_OLD_EMIT : S_FREE_SCAN;
					default:    state_d = S_IDLE;
				endcase
			end
			S_REPLY: begin
				if (emit_go) state_d = S_IDLE;
			end
			S_OLD_EMIT: begin
				if (emit_go) state_d = S_OLD_WR;
			end
			S_OLD_WR: begin
				state_d = (mode_q == MODE_WRITE) ? S_FREE_SCAN : S_IDLE;
			end
			S_FREE_SCAN: begin
				if (scan_done) state_d = found ? S_THR : S_REPLY;
			end
			S_THR: begin
				state_d = lt ? S_GIVE : S_USED_SCAN;
			end
			S_USED_SCAN: begin
				if (scan_done) state_d = found ? S_COPY : S_GIVE;
			end
			S_COPY: begin
				if (emit_go) state_d = S_REMAP;
			end
			S_REMAP: begin
				if (remap_hit || remap_end) state_d = S_USED_ZERO;
			end
			S_USED_ZERO: begin
				if (emit_go) state_d = S_GIVE;
			end
			S_GIVE: begin
				if (emit_go) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			thr_q      <= THR_RESET;
			valid_q    <= '0;
			sp_q       <= '0;
			rp_q       <= '0;
			smp_vld_s1 <= 1'b0;
			rm_vld_s1  <= 1'b0;
			m_vld_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) thr_q <= cfg_wdata;
			if (state_q == S_OLD_EMIT && emit_go) valid_q[lb_q] <= 1'b0;
			if (state_q == S_GIVE && emit_go)     valid_q[lb_q] <= 1'b1;
			if (in_scan || state_q == S_CLEAR) begin
				if (sp_q != SP_END) sp_q <= sp_q + 1'b1;
			end else begin
				sp_q <= '0;
			end
			smp_vld_s1 <= in_scan && (sp_q != SP_END);
			if (state_q == S_REMAP) begin
				if (rp_q != RP_END) rp_q <= rp_q + 1'b1;
			end else begin
				rp_q <= '0;
			end
			rm_vld_s1 <= (state_q == S_REMAP) && (rp_q != RP_END);
			if (emit_go)            m_vld_q <= 1'b1;
			else if (m_axis_tready) m_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		smp_idx_s1 <= sp_q[PW-1:0];
		rm_idx_s1  <= rp_q[LB_W-1:0];
		if (in_acc) begin
			mode_q <= s_axis_tuser;
			lb_q   <= s_axis_tdata[LB_W-1:0];
		end
		if (state_q == S_LOOKUP) old_q <= mm_rdata;
		if (state_q == S_THR) begin
			aim_q      <= best_idx;
			aim_cnt_q  <= best_cnt;
			give_q     <= best_idx;
			give_cnt_q <= best_cnt;
		end
		if (state_q == S_USED_SCAN && scan_done && found) begin
			used_q     <= best_idx;
			used_cnt_q <= best_cnt;
		end
		if (state_q == S_USED_ZERO && emit_go) begin
			give_q     <= used_q;
			give_cnt_q <= sat_inc(used_cnt_q);
		end
		if (emit_go) begin
			m_cmd_q  <= e_cmd;
			m_src_q  <= e_src;
			m_dst_q  <= e_dst;
			m_st_q   <= e_st;
			m_last_q <= e_last;
		end
	end

	// ---------------- command to emit ----------------
	always_comb begin
		emit_req = 1'b0;
		e_cmd    = CMD_NONE;
		e_src    = '0;
		e_dst    = '0;
		e_st     = ST_OK;
		e_last   = 1'b0;
		case (state_q)
			S_REPLY: begin
				emit_req = 1'b1;
				e_last   = 1'b1;
				if (mode_q == MODE_READ && map_hit) begin
					e_cmd = CMD_READ;
					e_src = blk_out(old_q);
				end else if (mode_q == MODE_WRITE) begin
					e_st = ST_NOFREE;
				end else begin
					e_st = ST_UNMAPPED;
				end
			end
			S_OLD_EMIT: begin
				emit_req = 1'b1;
				e_cmd    = CMD_ZERO;
				e_dst    = blk_out(old_q);
				e_last   = mode_q == MODE_ERASE;
			end
			S_COPY: begin
				emit_req = 1'b1;
				e_cmd    = CMD_COPY;
				e_src    = blk_out(used_q);
				e_dst    = blk_out(aim_q);
			end
			S_USED_ZERO: begin
				emit_req = 1'b1;
				e_cmd    = CMD_ZERO;
				e_dst    = blk_out(used_q);
			end
			S_GIVE: begin
				emit_req = 1'b1;
				e_cmd    = CMD_WRITE;
				e_dst    = blk_out(give_q);
				e_last   = 1'b1;
			end
			default: ;
		endcase
	end

	// ---------------- block status memory ----------------
	always_comb begin
		if (state_q inside {S_OLD_EMIT, S_OLD_WR}) bm_raddr = old_q;
		else if (sp_q != SP_END)                   bm_raddr = sp_q[PW-1:0];
		else                                       bm_raddr = '0;
	end

	always_comb begin
		bm_we    = 1'b0;
		bm_waddr = old_q;
		bm_wdata = '0;
		case (state_q)
			S_CLEAR: begin
				bm_we    = 1'b1;
				bm_waddr = sp_q[PW-1:0];
				bm_wdata = {1'b1, {CW{1'b0}}};
			end
			S_OLD_WR: begin
				bm_we    = 1'b1;
				bm_waddr = old_q;
				bm_wdata = {1'b1, sat_inc(bm_rdata[CW-1:0])};
			end
			S_COPY: begin
				bm_we    = emit_go;
				bm_waddr = aim_q;
				bm_wdata = {1'b0, aim_cnt_q};
			end
			S_USED_ZERO: begin
				bm_we    = emit_go;
				bm_waddr = used_q;
				bm_wdata = {1'b1, sat_inc(used_cnt_q)};
			end
			S_GIVE: begin
				bm_we    = emit_go;
				bm_waddr = give_q;
				bm_wdata = {1'b0, give_cnt_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (bm_we) bm[bm_waddr] <= bm_wdata;
		bm_rdata <= bm[bm_raddr];
	end

	// ---------------- logical map memory ----------------
	always_comb begin
		if (state_q == S_IDLE)       mm_raddr = s_axis_tdata[LB_W-1:0];
		else if (state_q == S_REMAP) mm_raddr = rp_q[LB_W-1:0];
		else                         mm_raddr = lb_q;
	end

	always_comb begin
		mm_we    = 1'b0;
		mm_waddr = lb_q;
		mm_wdata = give_q;
		if (remap_hit) begin
			mm_we    = 1'b1;
			mm_waddr = rm_idx_s1;
			mm_wdata = aim_q;
		end else if (state_q == S_GIVE && emit_go) begin
			mm_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mm_we) mm[mm_waddr] <= mm_wdata;
		mm_rdata <= mm[mm_raddr];
	end

	// ---------------- shared compare unit ----------------
	assign scan_ctl.sample  = smp_vld_s1;
	assign scan_ctl.first   = smp_idx_s1 == '0;
	assign scan_ctl.want    = state_q == S_FREE_SCAN;
	assign scan_ctl.thr_chk = state_q == S_THR;

	fwlt_min_scan #(
		.PW (PW),
		.CW (CW)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (scan_ctl),
		.smp_idx  (smp_idx_s1),
		.smp_cnt  (bm_rdata[CW-1:0]),
		.smp_free (bm_rdata[CW]),
		.thr      (thr_q),
		.found    (found),
		.best_idx (best_idx),
		.best_cnt (best_cnt),
		.lt       (lt)
	);

	// ---------------- outputs ----------------
	assign m_axis_tvalid = m_vld_q;
	assign m_axis_tdata  = {4'b0, m_st_q, m_dst_q, m_src_q};
	assign m_axis_tuser  = m_cmd_q;
	assign m_axis_tlast  = m_last_q;

	// ---------------- assertions ----------------
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !s_axis_tready)
		else $error("request taken while a previous one is in flight");

	a_none_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == CMD_NONE |-> m_axis_tlast)
		else $error("status-only transaction not closing its run");

	a_give_marks_used: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_GIVE) && emit_go |-> bm_we && !bm_wdata[CW])
		else $error("handed-out block not marked in use");

	a_thr_has_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_THR) |-> found)
		else $error("threshold check without a free block");

endmodule

`default_nettype wire
